// ----- rtl/core/efb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Elliptical falloff brush package
// Shared widths, constants, codes and types for the brush datapath.
// ----------------------------------------------------------------------------
package efb_pkg;

    localparam int MAX_RADIUS   = 256;
    localparam int COORD_W      = 9;
    localparam int RAD_W        = 16;
    localparam int RAD_FRAC_W   = 8;
    localparam int OUT_W        = 16;
    localparam int CFG_IDX_W    = 3;

    localparam int CRAW_W       = RAD_W + 1 - RAD_FRAC_W;
    localparam int CENTRE_W     = $clog2(MAX_RADIUS + 1);
    localparam int AX_W         = (COORD_W > CENTRE_W) ? COORD_W : CENTRE_W;
    localparam int DX_W         = AX_W + 1;

    localparam int SQ_W         = 2 * RAD_W;
    localparam int AX2_W        = 2 * AX_W;
    localparam int TERM_W       = SQ_W + AX2_W;
    localparam int Q_W          = TERM_W + 1;
    localparam int LIM_SHIFT    = 16;
    localparam int LIM_W        = 2 * SQ_W - LIM_SHIFT;
    localparam int P_SHIFT      = 4;
    localparam int P_W          = SQ_W - P_SHIFT;
    localparam int RAD_SH       = 8;
    localparam int RADICAND_W   = Q_W + RAD_SH;
    localparam int SQRT_IN_W    = RADICAND_W + (RADICAND_W % 2);
    localparam int SQRT_STEPS   = SQRT_IN_W / 2;
    localparam int ROOT_W       = SQRT_STEPS;
    localparam int REM_W        = ROOT_W + 2;
    localparam int DIFF_W       = ((ROOT_W > P_W) ? ROOT_W : P_W) + 1;
    localparam int NUM_W        = ROOT_W + 1 + DIFF_W;
    localparam int M_W          = P_W + ROOT_W;
    localparam int MAG_W        = NUM_W - 1;

    localparam int T_FRAC_W     = 16;
    localparam int T_W          = T_FRAC_W + 1;
    localparam int DIV_STEPS    = T_FRAC_W;
    localparam int TSQ_W        = 2 * T_W;
    localparam int PROD_W       = T_W + 1 + OUT_W;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int BACK_LAT     = 3 + SQRT_STEPS + 3 + DIV_STEPS + 3;

    localparam logic [T_W-1:0]   T_ONE       = T_W'(1) << T_FRAC_W;
    localparam logic [RAD_W-1:0] RESET_OUTER = 16'd1024;
    localparam logic [RAD_W-1:0] RESET_INNER = 16'd512;
    localparam logic [OUT_W-1:0] RESET_WEIGHT = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_X  = 3'd0,
        CFG_INNER_X  = 3'd1,
        CFG_OUTER_Y  = 3'd2,
        CFG_INNER_Y  = 3'd3,
        CFG_WEIGHT   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TSEL_ZERO = 2'd0,
        TSEL_ONE  = 2'd1,
        TSEL_DIV  = 2'd2
    } t_tsel;

    typedef struct packed {
        logic        [RAD_W-1:0] outer_radius_x;
        logic        [RAD_W-1:0] inner_radius_x;
        logic        [RAD_W-1:0] outer_radius_y;
        logic        [RAD_W-1:0] inner_radius_y;
        logic signed [OUT_W-1:0] brush_weight;
    } t_cfg;

    typedef struct packed {
        logic [AX_W-1:0] ax;
        logic [AX_W-1:0] ay;
    } t_item;

endpackage
`default_nettype wire

// ----- rtl/core/efb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Brush item queue
// Small FIFO between the front and the back; the head is drained every
// cycle it holds a word.
// ----------------------------------------------------------------------------
module efb_queue
    import efb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_vld,
    output t_item o_item
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QIDX_W-1:0]   r_wr_ptr;
    logic [QIDX_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                pop;
    logic                push;

    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_item = r_mem[r_rd_ptr];
    assign pop    = o_vld;
    assign push   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ----- rtl/core/efb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Brush front end
// Holds the configuration registers, accepts pixels and turns each into its
// absolute offset from the brush centre before it enters the queue.
// ----------------------------------------------------------------------------
module efb_front
    import efb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [COORD_W-1:0]   i_pixel_col,
    input  logic [COORD_W-1:0]   i_pixel_row,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [OUT_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_item                o_item
);

    t_cfg                   r_cfg;
    t_item                  r_item;
    logic                   r_vld;
    t_item                  n_item;
    logic [RAD_W:0]         sum_x;
    logic [RAD_W:0]         sum_y;
    logic [CRAW_W-1:0]      raw_x;
    logic [CRAW_W-1:0]      raw_y;
    logic [CENTRE_W-1:0]    cx;
    logic [CENTRE_W-1:0]    cy;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;

    assign o_cfg  = r_cfg;
    assign o_busy = r_vld && i_q_full;
    assign o_push = r_vld && !i_q_full;
    assign o_item = r_item;

    always_comb begin
        sum_x = {1'b0, r_cfg.outer_radius_x} + (RAD_W + 1)'((1 << RAD_FRAC_W) - 1);
        sum_y = {1'b0, r_cfg.outer_radius_y} + (RAD_W + 1)'((1 << RAD_FRAC_W) - 1);
        raw_x = sum_x[RAD_W:RAD_FRAC_W];
        raw_y = sum_y[RAD_W:RAD_FRAC_W];
        cx    = (raw_x > MAX_RADIUS) ? CENTRE_W'(MAX_RADIUS) : CENTRE_W'(raw_x);
        cy    = (raw_y > MAX_RADIUS) ? CENTRE_W'(MAX_RADIUS) : CENTRE_W'(raw_y);
        dx    = $signed(DX_W'(i_pixel_col)) - $signed(DX_W'(cx));
        dy    = $signed(DX_W'(i_pixel_row)) - $signed(DX_W'(cy));
        n_item.ax = AX_W'(dx[DX_W-1] ? -dx : dx);
        n_item.ay = AX_W'(dy[DX_W-1] ? -dy : dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_radius_x <= RESET_OUTER;
            r_cfg.inner_radius_x <= RESET_INNER;
            r_cfg.outer_radius_y <= RESET_OUTER;
            r_cfg.inner_radius_y <= RESET_INNER;
            r_cfg.brush_weight   <= RESET_WEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OUTER_X: r_cfg.outer_radius_x <= i_cfg_data;
                CFG_INNER_X: r_cfg.inner_radius_x <= i_cfg_data;
                CFG_OUTER_Y: r_cfg.outer_radius_y <= i_cfg_data;
                CFG_INNER_Y: r_cfg.inner_radius_y <= i_cfg_data;
                CFG_WEIGHT:  r_cfg.brush_weight   <= i_cfg_data;
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_busy) begin
            r_vld <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/efb_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage, one radicand per cycle.
// ----------------------------------------------------------------------------
module efb_sqrt
    import efb_pkg::*;
(
    input  logic                 i_clk,
    input  logic [SQRT_IN_W-1:0] i_radicand,
    output logic [ROOT_W-1:0]    o_root
);

    logic [SQRT_IN_W-1:0] r_x    [SQRT_STEPS];
    logic [REM_W-1:0]     r_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0]    r_root [SQRT_STEPS];

    assign o_root = r_root[SQRT_STEPS-1];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [SQRT_IN_W-1:0] x_in;
        logic [REM_W-1:0]     rem_in;
        logic [ROOT_W-1:0]    root_in;
        logic [REM_W+1:0]     rem_sh;
        logic [REM_W+1:0]     trial;

        if (k == 0) begin : g_first
            assign x_in    = i_radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign rem_sh = {rem_in, x_in[SQRT_IN_W-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            r_x[k] <= x_in << 2;
            if (rem_sh >= trial) begin
                r_rem[k]  <= REM_W'(rem_sh - trial);
                r_root[k] <= {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_sh[REM_W-1:0];
                r_root[k] <= {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/efb_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Restoring division giving the Q0.16 fraction of a numerator below its
// denominator, one quotient bit per stage.
// ----------------------------------------------------------------------------
module efb_div
    import efb_pkg::*;
(
    input  logic                i_clk,
    input  logic [MAG_W-1:0]    i_num,
    input  logic [MAG_W-1:0]    i_den,
    output logic [T_FRAC_W-1:0] o_quot
);

    logic [MAG_W-1:0]    r_rem  [DIV_STEPS];
    logic [MAG_W-1:0]    r_den  [DIV_STEPS];
    logic [T_FRAC_W-1:0] r_quot [DIV_STEPS];

    assign o_quot = r_quot[DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [MAG_W-1:0]    rem_in;
        logic [MAG_W-1:0]    den_in;
        logic [T_FRAC_W-1:0] quot_in;
        logic [MAG_W:0]      rem_sh;

        if (k == 0) begin : g_first
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quot_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quot_in = r_quot[k-1];
        end

        assign rem_sh = {rem_in, 1'b0};

        always_ff @(posedge i_clk) begin
            r_den[k] <= den_in;
            if (rem_sh >= {1'b0, den_in}) begin
                r_rem[k]  <= MAG_W'(rem_sh - {1'b0, den_in});
                r_quot[k] <= {quot_in[T_FRAC_W-2:0], 1'b1};
            end else begin
                r_rem[k]  <= rem_sh[MAG_W-1:0];
                r_quot[k] <= {quot_in[T_FRAC_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/efb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Brush back end
// Fixed-latency pipeline: ellipse test, ray lengths, falloff ratio, falloff
// squared and weighting.
// ----------------------------------------------------------------------------
module efb_back
    import efb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  t_item                   i_item,
    input  t_cfg                    i_cfg,
    output logic                    o_vld,
    output logic signed [OUT_W-1:0] o_brush_value,
    output logic [OUT_W-1:0]        o_falloff_level
);

    logic [BACK_LAT-1:0]     r_vld;

    logic [AX2_W-1:0]        r1_ax2, r1_ay2;
    logic [SQ_W-1:0]         r1_ia2, r1_ib2, r1_oa2, r1_ob2, r1_iab, r1_oab;

    logic [TERM_W-1:0]       r2_tin_a, r2_tin_b, r2_tout_a, r2_tout_b;
    logic [LIM_W-1:0]        r2_lim;
    logic [P_W-1:0]          r2_pin, r2_pout;
    logic [2*SQ_W-1:0]       lim_full;

    logic [Q_W-1:0]          qin, qout;
    logic [SQRT_IN_W-1:0]    r3_rin, r3_rout;
    logic                    r3_outside;
    logic [P_W-1:0]          r3_pin, r3_pout;

    logic                    r_sb_outside [SQRT_STEPS];
    logic [P_W-1:0]          r_sb_pin     [SQRT_STEPS];
    logic [P_W-1:0]          r_sb_pout    [SQRT_STEPS];
    logic [ROOT_W-1:0]       din, dout;

    logic signed [DIFF_W-1:0] diff;
    logic signed [ROOT_W:0]   dout_s;
    logic signed [NUM_W-1:0]  r4_num;
    logic [M_W-1:0]           r4_m1, r4_m2;
    logic                     r4_outside;

    logic signed [NUM_W-1:0]  r5_num, r5_den;
    logic                     r5_outside;

    logic [MAG_W-1:0]         un, ud;
    t_tsel                    n_tsel;
    logic [MAG_W-1:0]         r6_un, r6_ud;
    t_tsel                    r6_tsel;
    t_tsel                    r_tsel_d [DIV_STEPS];
    logic [T_FRAC_W-1:0]      quot;

    logic [T_W-1:0]           t_val;
    logic [TSQ_W-1:0]         r7_tsq;
    logic [T_W-1:0]           f_val;
    logic signed [PROD_W-1:0] r8_prod;
    logic [T_W-1:0]           r8_f;

    logic signed [OUT_W-1:0]  r_brush_value;
    logic [OUT_W-1:0]         r_falloff_level;

    assign o_vld           = r_vld[BACK_LAT-1];
    assign o_brush_value   = r_brush_value;
    assign o_falloff_level = r_falloff_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[BACK_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ax2 <= i_item.ax * i_item.ax;
        r1_ay2 <= i_item.ay * i_item.ay;
        r1_ia2 <= i_cfg.inner_radius_x * i_cfg.inner_radius_x;
        r1_ib2 <= i_cfg.inner_radius_y * i_cfg.inner_radius_y;
        r1_oa2 <= i_cfg.outer_radius_x * i_cfg.outer_radius_x;
        r1_ob2 <= i_cfg.outer_radius_y * i_cfg.outer_radius_y;
        r1_iab <= i_cfg.inner_radius_x * i_cfg.inner_radius_y;
        r1_oab <= i_cfg.outer_radius_x * i_cfg.outer_radius_y;
    end

    assign lim_full = r1_ia2 * r1_ib2;

    always_ff @(posedge i_clk) begin
        r2_tin_a  <= r1_ib2 * r1_ax2;
        r2_tin_b  <= r1_ia2 * r1_ay2;
        r2_tout_a <= r1_ob2 * r1_ax2;
        r2_tout_b <= r1_oa2 * r1_ay2;
        r2_lim    <= lim_full[2*SQ_W-1:LIM_SHIFT];
        r2_pin    <= r1_iab[SQ_W-1:P_SHIFT];
        r2_pout   <= r1_oab[SQ_W-1:P_SHIFT];
    end

    assign qin  = {1'b0, r2_tin_a} + {1'b0, r2_tin_b};
    assign qout = {1'b0, r2_tout_a} + {1'b0, r2_tout_b};

    always_ff @(posedge i_clk) begin
        r3_rin     <= SQRT_IN_W'({qin, {RAD_SH{1'b0}}});
        r3_rout    <= SQRT_IN_W'({qout, {RAD_SH{1'b0}}});
        r3_outside <= (qin > Q_W'(r2_lim));
        r3_pin     <= r2_pin;
        r3_pout    <= r2_pout;
    end

    efb_sqrt u_sqrt_in (
        .i_clk      (i_clk),
        .i_radicand (r3_rin),
        .o_root     (din)
    );

    efb_sqrt u_sqrt_out (
        .i_clk      (i_clk),
        .i_radicand (r3_rout),
        .o_root     (dout)
    );

    always_ff @(posedge i_clk) begin
        r_sb_outside[0] <= r3_outside;
        r_sb_pin[0]     <= r3_pin;
        r_sb_pout[0]    <= r3_pout;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            r_sb_outside[k] <= r_sb_outside[k-1];
            r_sb_pin[k]     <= r_sb_pin[k-1];
            r_sb_pout[k]    <= r_sb_pout[k-1];
        end
    end

    assign diff   = $signed(DIFF_W'(din)) - $signed(DIFF_W'(r_sb_pin[SQRT_STEPS-1]));
    assign dout_s = $signed({1'b0, dout});

    always_ff @(posedge i_clk) begin
        r4_num     <= dout_s * diff;
        r4_m1      <= r_sb_pout[SQRT_STEPS-1] * din;
        r4_m2      <= r_sb_pin[SQRT_STEPS-1] * dout;
        r4_outside <= r_sb_outside[SQRT_STEPS-1];
    end

    always_ff @(posedge i_clk) begin
        r5_num     <= r4_num;
        r5_den     <= $signed(NUM_W'(r4_m1)) - $signed(NUM_W'(r4_m2));
        r5_outside <= r4_outside;
    end

    always_comb begin
        un = MAG_W'(r5_num[NUM_W-1] ? -r5_num : r5_num);
        ud = MAG_W'(r5_den[NUM_W-1] ? -r5_den : r5_den);
        if (!r5_outside) begin
            n_tsel = TSEL_ZERO;
        end else if (r5_den == '0) begin
            n_tsel = TSEL_ONE;
        end else if (r5_num == '0 || (r5_num[NUM_W-1] != r5_den[NUM_W-1])) begin
            n_tsel = TSEL_ZERO;
        end else if (un >= ud) begin
            n_tsel = TSEL_ONE;
        end else begin
            n_tsel = TSEL_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_un   <= un;
        r6_ud   <= ud;
        r6_tsel <= n_tsel;
    end

    efb_div u_div (
        .i_clk  (i_clk),
        .i_num  (r6_un),
        .i_den  (r6_ud),
        .o_quot (quot)
    );

    always_ff @(posedge i_clk) begin
        r_tsel_d[0] <= r6_tsel;
        for (int k = 1; k < DIV_STEPS; k++) begin
            r_tsel_d[k] <= r_tsel_d[k-1];
        end
    end

    always_comb begin
        case (r_tsel_d[DIV_STEPS-1])
            TSEL_ZERO: t_val = '0;
            TSEL_ONE:  t_val = T_ONE;
            default:   t_val = {1'b0, quot};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r7_tsq <= t_val * t_val;
    end

    assign f_val = T_ONE - T_W'(r7_tsq >> T_FRAC_W);

    always_ff @(posedge i_clk) begin
        r8_f    <= f_val;
        r8_prod <= $signed({1'b0, f_val}) * i_cfg.brush_weight;
    end

    always_ff @(posedge i_clk) begin
        r_brush_value   <= r8_prod[T_FRAC_W +: OUT_W];
        r_falloff_level <= r8_f[T_FRAC_W] ? '1 : r8_f[OUT_W-1:0];
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[BACK_LAT-1] |-> $past(i_vld, BACK_LAT))
        else $error("result without a matching pixel");

endmodule
`default_nettype wire

// ----- rtl/core/elliptical_falloff_brush.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Elliptical falloff brush
// Gives the falloff-weighted brush value of one pixel from its offset to
// the centre of an inner and an outer ellipse.
// Path: start is registered in the front end and passes the queue, then the back
// end, which holds the two 30-stage square root pipelines and the 16-stage divider.
// Throughput: one pixel per clock; busy rises only if the queue fills.
// Reset: synchronous; clears the pipeline valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module elliptical_falloff_brush
    import efb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [COORD_W-1:0]      i_pixel_col,
    input  logic [COORD_W-1:0]      i_pixel_row,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [OUT_W-1:0]        i_cfg_data,
    output logic                    o_result_valid,
    output logic signed [OUT_W-1:0] o_brush_value,
    output logic [OUT_W-1:0]        o_falloff_level
);

    t_cfg  cfg;
    t_item front_item;
    t_item queue_item;
    logic  push;
    logic  q_full;
    logic  q_vld;

    assign o_cfg_ready = 1'b1;

    efb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (front_item)
    );

    efb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_item  (queue_item)
    );

    efb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (q_vld),
        .i_item          (queue_item),
        .i_cfg           (cfg),
        .o_vld           (o_result_valid),
        .o_brush_value   (o_brush_value),
        .o_falloff_level (o_falloff_level)
    );

    a_zero_falloff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_falloff_level == '0) |-> (o_brush_value == '0))
        else $error("nonzero value with zero falloff");

endmodule
`default_nettype wire

// ----- test/elliptical_falloff_brush_tb.sv -----
// ----------------------------------------------------------------------------
// Elliptical falloff brush testbench
// Drives pixel coordinates and register writes into the brush, predicts each
// brush value and falloff level from its own fixed-point model of the two
// ellipses, and checks every result word in order against the prediction.
// ----------------------------------------------------------------------------
class brush_scoreboard;
    typedef struct {
        logic signed [15:0] value;
        logic [15:0]        level;
    } brush_word_t;

    brush_word_t        pending_words[$];
    longint unsigned    outer_x, inner_x, outer_y, inner_y;
    longint             weight;
    int                 mismatches;

    function new();
        outer_x = 1024;
        inner_x = 512;
        outer_y = 1024;
        inner_y = 512;
        weight = 256;
        mismatches = 0;
    endfunction

    function void write_reg(efb_pkg::t_cfg_idx idx, logic [15:0] data);
        case (idx)
            efb_pkg::CFG_OUTER_X: outer_x = data;
            efb_pkg::CFG_INNER_X: inner_x = data;
            efb_pkg::CFG_OUTER_Y: outer_y = data;
            efb_pkg::CFG_INNER_Y: inner_y = data;
            efb_pkg::CFG_WEIGHT:  weight = longint'($signed(data));
            default: ;
        endcase
    endfunction

    static function longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    static function longint unsigned centre_pixel(longint unsigned r);
        longint unsigned c;
        c = (r + 255) >> 8;
        return (c > 256) ? 256 : c;
    endfunction

    static function longint unsigned crossing_len(longint unsigned a, longint unsigned b,
                                                  longint unsigned ax, longint unsigned ay);
        return root_floor((b * b * ax * ax + a * a * ay * ay) << 8);
    endfunction

    static function longint unsigned ratio_q16(longint unsigned n, longint unsigned d);
        longint unsigned r;
        longint unsigned q;
        r = n;
        q = 0;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function void note_pixel(logic [8:0] col, logic [8:0] row);
        longint          dx, dy, din, dout, pin, pout, num, den, prod;
        longint unsigned ax, ay, qin, lim, t, f;
        brush_word_t     w;
        dx = longint'(col) - longint'(centre_pixel(outer_x));
        dy = longint'(row) - longint'(centre_pixel(outer_y));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        f = 65536;
        qin = inner_y * inner_y * ax * ax + inner_x * inner_x * ay * ay;
        lim = ((inner_x * inner_x) * (inner_y * inner_y)) >> 16;
        if (qin > lim) begin
            din = crossing_len(inner_x, inner_y, ax, ay);
            dout = crossing_len(outer_x, outer_y, ax, ay);
            pin = (inner_x * inner_y) >> 4;
            pout = (outer_x * outer_y) >> 4;
            num = dout * (din - pin);
            den = pout * din - pin * dout;
            if (den == 0) begin
                t = 65536;
            end else if (num == 0 || ((num < 0) != (den < 0))) begin
                t = 0;
            end else begin
                ax = (num < 0) ? -num : num;
                ay = (den < 0) ? -den : den;
                t = (ax >= ay) ? 65536 : ratio_q16(ax, ay);
            end
            f = 65536 - ((t * t) >> 16);
        end
        prod = longint'(f) * weight;
        w.value = 16'(prod >>> 16);
        w.level = (f > 65535) ? 16'hFFFF : 16'(f);
        pending_words.push_back(w);
    endfunction

    function void check_word(logic signed [15:0] value, logic [15:0] level);
        brush_word_t w;
        if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result word: value %0d level %0d", value, level);
            return;
        end
        w = pending_words.pop_front();
        if (w.value !== value || w.level !== level) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result word differs: expected value %0d level %0d, got %0d %0d",
                         w.value, w.level, value, level);
        end
    endfunction

    function int pending();
        return pending_words.size();
    endfunction
endclass

module elliptical_falloff_brush_tb;
    import efb_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [COORD_W-1:0]      i_pixel_col = '0;
    logic [COORD_W-1:0]      i_pixel_row = '0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [OUT_W-1:0]        i_cfg_data = '0;
    logic                    o_result_valid;
    logic signed [OUT_W-1:0] o_brush_value;
    logic [OUT_W-1:0]        o_falloff_level;

    brush_scoreboard brush_sb = new();
    int              idle_pct = 0;

    elliptical_falloff_brush u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_pixel_col     (i_pixel_col),
        .i_pixel_row     (i_pixel_row),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_valid  (o_result_valid),
        .o_brush_value   (o_brush_value),
        .o_falloff_level (o_falloff_level)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            brush_sb.check_word(o_brush_value, o_falloff_level);
    end

    initial begin
        #3000000;
        $display("elliptical_falloff_brush: mismatch");
        $finish;
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        brush_sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_brush(logic [15:0] ox, logic [15:0] ix, logic [15:0] oy,
                             logic [15:0] iy, logic [15:0] wt);
        write_reg(CFG_OUTER_X, ox);
        write_reg(CFG_INNER_X, ix);
        write_reg(CFG_OUTER_Y, oy);
        write_reg(CFG_INNER_Y, iy);
        write_reg(CFG_WEIGHT, wt);
    endtask

    // Pixels go out back to back but for random idle_pct gaps, where start is low.
    task automatic send_pixel(logic [8:0] col, logic [8:0] row);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_pixel_col = col;
        i_pixel_row = row;
        do @(posedge i_clk); while (busy);
        brush_sb.note_pixel(col, row);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (brush_sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_near(int spread);
        int cx, cy;
        cx = int'(brush_sb.centre_pixel(brush_sb.outer_x));
        cy = int'(brush_sb.centre_pixel(brush_sb.outer_y));
        if ($urandom_range(99) < 20)
            send_pixel(9'($urandom), 9'($urandom));
        else
            send_pixel(9'(cx + $urandom_range(2 * spread) - spread),
                       9'(cy + $urandom_range(2 * spread) - spread));
    endtask

    initial begin
        int phase_idle[8] = '{0, 69, 18, 0, 69, 18, 0, 69};
        logic [15:0] ox, oy;
        int spread;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default brush: centre, axes, boundaries and far corners.
        send_pixel(9'd4, 9'd4);
        send_pixel(9'd4, 9'd6);
        send_pixel(9'd4, 9'd7);
        send_pixel(9'd7, 9'd4);
        send_pixel(9'd8, 9'd8);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd511);
        drain();
        // Inner equal to outer: zero denominator.
        set_brush(16'd1536, 16'd1536, 16'd768, 16'd768, 16'h7FFF);
        send_pixel(9'd6, 9'd6);
        send_pixel(9'd20, 9'd3);
        send_pixel(9'd6, 9'd4);
        drain();
        // Zero inner radii and most negative weight.
        set_brush(16'd2048, 16'd0, 16'd2048, 16'd0, 16'h8000);
        send_pixel(9'd8, 9'd8);
        send_pixel(9'd9, 9'd8);
        send_pixel(9'd12, 9'd8);
        drain();
        // Largest radii: centre reaches its maximum of 256; inner x equal to outer x.
        set_brush(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFF01);
        send_pixel(9'd256, 9'd256);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd256, 9'd300);
        drain();
        set_brush(16'd0, 16'd300, 16'd0, 16'd300, 16'd0);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd3, 9'd1);
        send_pixel(9'd300, 9'd200);
        drain();

        for (int p = 0; p < 8; p++) begin
            idle_pct = phase_idle[p];
            if (p % 3 == 2) begin
                ox = 16'($urandom);
                oy = 16'($urandom);
            end else begin
                ox = 16'($urandom_range(4096));
                oy = 16'($urandom_range(4096));
            end
            set_brush(ox, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(ox)),
                      oy, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(oy)),
                      16'($urandom));
            spread = int'((ox > oy ? ox : oy) >> 8) + 3;
            if (spread > 300) spread = 300;
            for (int n = 0; n < 212; n++) send_near(spread);
            drain();
        end

        if (brush_sb.mismatches == 0 && brush_sb.pending() == 0) begin
            $display("elliptical_falloff_brush: match");
        end else begin
            $display("elliptical_falloff_brush: mismatch");
        end
        $finish;
    end
endmodule
